>>> hdl/dest_pkg.sv
`timescale 1ns / 1ps

package dest_pkg;

   // table size and derived widths
   localparam int CAPACITY = 16;
   localparam int SLOT_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W    = $clog2(CAPACITY + 1);

   // fixed field widths
   localparam int OP_W    = 2;
   localparam int ELEM_W  = 32;
   localparam int COUNT_W = 5;

   // operation codes; the unused code behaves as a look up
   typedef enum logic [OP_W-1:0] {
      OP_INSERT = 2'd0,
      OP_REMOVE = 2'd1,
      OP_LOOKUP = 2'd2
   } op_type;

   // search packet that walks down the chain of cells
   typedef struct packed {
      logic                     active;
      op_type                   op;
      logic signed [ELEM_W-1:0] element;
      logic                     hit;
      logic                     free_found;
      logic [SLOT_W-1:0]        free_idx;
   } pkt_type;

endpackage

>>> hdl/dest_cell.sv
`timescale 1ns / 1ps

module dest_cell (
   input  logic                             clock,
   input  logic                             reset,
   input  logic [dest_pkg::SLOT_W-1:0]      slot_index,
   input  dest_pkg::pkt_type                pkt_in,
   output dest_pkg::pkt_type                pkt_out,
   input  logic                             wr_en,
   input  logic signed [dest_pkg::ELEM_W-1:0] wr_element,
   output logic                             valid_out
);
   import dest_pkg::*;

   logic signed [ELEM_W-1:0] value_ff;
   logic signed [ELEM_W-1:0] value_in;
   logic                     valid_ff;
   logic                     valid_in;
   pkt_type                  pkt_ff;
   pkt_type                  pkt_in_next;
   logic                     match;

   assign match = valid_ff && (value_ff == pkt_in.element);

   // mark hit and lowest free slot on the passing packet
   always_comb begin
      pkt_in_next = pkt_in;
      if (pkt_in.active) begin
         if (match) begin
            pkt_in_next.hit = 1'b1;
         end
         if (!valid_ff && !pkt_in.free_found) begin
            pkt_in_next.free_found = 1'b1;
            pkt_in_next.free_idx   = slot_index;
         end
      end
   end

   always_comb begin
      priority if (wr_en) begin
         valid_in = 1'b1;
      end else if (pkt_in.active && match && (pkt_in.op == OP_REMOVE)) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   assign value_in = wr_en ? wr_element : value_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= 1'b0;
         pkt_ff.active <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         pkt_ff   <= pkt_in_next;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign pkt_out   = pkt_ff;
   assign valid_out = valid_ff;

endmodule

>>> hdl/distinct_element_set_table_core.sv
`timescale 1ns / 1ps

// Set of up to CAPACITY (16) distinct signed 32-bit elements. Each request
// transaction inserts, removes or looks up one element and yields exactly one
// response transaction with was_present, changed, full_refused and the element
// count after the request. The elements live in a chain of cells, one entry
// per cell; a search packet enters cell 0 on the accepting edge and moves one
// cell per clock, collecting the match and the lowest free slot, and a remove
// clears the matching cell as the packet passes. After the last cell the
// packet lands in a finish register, where an insert is written into the free
// slot and the response is loaded into the output register. One request
// occupies the block through the walk down the chain and the finish step; the
// next request is taken once the previous result has moved into the output
// register, even while that result is still stalled. The table is empty after
// reset; no clearing pass is needed.

module distinct_element_set_table_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [dest_pkg::OP_W-1:0]          req_operation,
   input  logic signed [dest_pkg::ELEM_W-1:0] req_element,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic                               rsp_was_present,
   output logic                               rsp_changed,
   output logic                               rsp_full_refused,
   output logic [dest_pkg::COUNT_W-1:0]       rsp_count
);
   import dest_pkg::*;

   // chain links: link 0 is the injected packet, link CAPACITY is the tail
   pkt_type               chain [0:CAPACITY];
   logic [CAPACITY-1:0]   valid_vec;
   logic [CAPACITY-1:0]   wr_sel;

   logic                  req_accept;
   logic                  busy_ff;
   logic                  busy_in;

   // finish stage holding the packet that left the chain
   logic                  fin_valid_ff;
   logic                  fin_valid_in;
   pkt_type               fin_ff;
   logic                  fin_move;

   logic [CNT_W-1:0]      count_ff;
   logic [CNT_W-1:0]      count_in;

   // decision for the finishing transaction
   logic                  do_insert;
   logic                  do_remove;
   logic                  refused;

   // output register
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   logic                  rsp_was_present_ff;
   logic                  rsp_changed_ff;
   logic                  rsp_full_refused_ff;
   logic [COUNT_W-1:0]    rsp_count_ff;

   // one transaction in flight at a time
   assign req_stall  = busy_ff;
   assign req_accept = req_valid && !req_stall;

   // inject a fresh packet into cell 0 on the accepting edge
   always_comb begin
      chain[0]            = '0;
      chain[0].active     = req_accept;
      chain[0].op         = op_type'(req_operation);
      chain[0].element    = req_element;
      chain[0].hit        = 1'b0;
      chain[0].free_found = 1'b0;
   end

   genvar g;
   generate
      for (g = 0; g < CAPACITY; g++) begin : g_cell
         assign wr_sel[g] = fin_move && do_insert && (fin_ff.free_idx == SLOT_W'(g));

         dest_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .slot_index (SLOT_W'(g)),
            .pkt_in     (chain[g]),
            .pkt_out    (chain[g+1]),
            .wr_en      (wr_sel[g]),
            .wr_element (fin_ff.element),
            .valid_out  (valid_vec[g])
         );
      end
   endgenerate

   // result of the walk; unused op code falls through as a look up
   always_comb begin
      do_insert = 1'b0;
      do_remove = 1'b0;
      refused   = 1'b0;
      unique case (fin_ff.op)
         OP_INSERT: begin
            do_insert = !fin_ff.hit && fin_ff.free_found;
            refused   = !fin_ff.hit && !fin_ff.free_found;
         end
         OP_REMOVE: begin
            do_remove = fin_ff.hit;
         end
         default: begin
         end
      endcase
   end

   // finish moves out once the output register is free
   assign fin_move = fin_valid_ff && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      busy_in      = busy_ff;
      fin_valid_in = fin_valid_ff;
      rsp_valid_in = rsp_valid_ff;
      count_in     = count_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (chain[CAPACITY].active) begin
         fin_valid_in = 1'b1;
      end
      if (fin_move) begin
         fin_valid_in = 1'b0;
         busy_in      = 1'b0;
         rsp_valid_in = 1'b1;
         if (do_insert) begin
            count_in = count_ff + CNT_W'(1);
         end else if (do_remove) begin
            count_in = count_ff - CNT_W'(1);
         end
      end
      if (req_accept) begin
         busy_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         fin_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
      end else begin
         busy_ff      <= busy_in;
         fin_valid_ff <= fin_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (chain[CAPACITY].active) begin
         fin_ff <= chain[CAPACITY];
      end
      if (fin_move) begin
         rsp_was_present_ff  <= fin_ff.hit;
         rsp_changed_ff      <= do_insert || do_remove;
         rsp_full_refused_ff <= refused;
         rsp_count_ff        <= COUNT_W'(count_in);
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_was_present  = rsp_was_present_ff;
   assign rsp_changed      = rsp_changed_ff;
   assign rsp_full_refused = rsp_full_refused_ff;
   assign rsp_count        = rsp_count_ff;

   // stored count never exceeds the table size
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("stored count above capacity");

   // between transactions the count matches the occupied cells
   a_count_matches_cells: assert property (@(posedge clock) disable iff (reset)
      !busy_ff |-> ($countones(valid_vec) == count_ff))
      else $error("count differs from occupied cells");

   // a result never reports both a change and a refusal
   a_change_xor_refuse: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_changed_ff && rsp_full_refused_ff))
      else $error("result both changed and refused");

   // an accepted transaction blocks further requests on the next cycle
   a_single_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> req_stall)
      else $error("second transaction admitted while busy");

endmodule
